### hdl/fsr_pkg.sv
// Shared constants, types and helpers for the Frechet segment reachability block.
`default_nettype none

package fsr_pkg;

  // Width of the squared threshold register.
  localparam int EPS_BITS = 33;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON_SQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX = 3'd5;

  // Result codes.
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_NEW  = 2'd0;
  localparam outcome_t OUT_KEPT = 2'd1;
  localparam outcome_t OUT_DEAD = 2'd2;

  // Digit width of the shared multiplier.
  localparam int MUL_DIGIT = 16;

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

endpackage

`default_nettype wire

### hdl/fsr_mul.sv
// Iterative signed multiplier, one digit of the second operand per cycle.
`default_nettype none

module fsr_mul #(
  parameter int MW = 76
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic                      done,
  output logic signed [2*MW-1:0]    p
);
  import fsr_pkg::*;

  localparam int DG   = MUL_DIGIT;
  localparam int NDIG = (MW + DG - 1) / DG;
  localparam int BW   = NDIG * DG;
  localparam int AW   = MW + BW;
  localparam int CNW  = $clog2(NDIG + 1);

  typedef enum logic {M_IDLE, M_RUN} mstate_t;

  mstate_t          state_r;
  logic [CNW-1:0]   cnt_r;
  logic             done_r;
  logic             neg_r;
  logic [MW-1:0]    am_r;
  logic [BW-1:0]    bs_r;
  logic [AW-1:0]    acc_r;

  logic [MW-1:0]    a_mag;
  logic [MW-1:0]    b_mag;
  logic [MW+DG-1:0] pp;
  logic [MW+DG-1:0] t;
  logic [AW-1:0]    acc_nxt;

  assign a_mag   = a[MW-1] ? MW'(-a) : a;
  assign b_mag   = b[MW-1] ? MW'(-b) : b;
  assign pp      = am_r * bs_r[DG-1:0];
  assign t       = pp + {{DG{1'b0}}, acc_r[AW-1:BW]};
  assign acc_nxt = {t, acc_r[BW-1:DG]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            am_r    <= a_mag;
            bs_r    <= BW'(b_mag);
            acc_r   <= '0;
            neg_r   <= a[MW-1] ^ b[MW-1];
            cnt_r   <= CNW'(NDIG);
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= acc_nxt;
          bs_r  <= bs_r >> DG;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNW'(1)) begin
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign p    = neg_r ? -$signed(acc_r[2*MW-1:0]) : $signed(acc_r[2*MW-1:0]);

endmodule

`default_nettype wire

### hdl/frechet_segment_reachability.sv
// Top level: Frechet decision of a point stream against one configured segment.
// Each item is handled in turn: the sequencer issues its multiplications one after another to
// the shared multiplier, whose operands hold NDIG 16-bit digits (5 at 16-bit coordinates);
// an item that meets the sticky unreachable state skips them. A new item is taken only once
// the result of the last one is registered; the finishing state waits while the output register
// is full. Reset (synchronous, active low) clears config and restriction.
`default_nettype none

module frechet_segment_reachability #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Configuration write port.
  input  wire logic                                  cfg_we,
  input  wire logic [fsr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fsr_pkg::max3(fsr_pkg::EPS_BITS, COORD_BITS, INDEX_BITS)-1:0] cfg_wdata,
  // Input point channel.
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [COORD_BITS-1:0]          in_point_x,
  input  wire logic signed [COORD_BITS-1:0]          in_point_y,
  input  wire logic [INDEX_BITS-1:0]                 in_point_index,
  input  wire logic                                  in_restart,
  // Result channel.
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output fsr_pkg::outcome_t                          out_outcome,
  output logic [INDEX_BITS-1:0]                      out_restriction_index
);
  import fsr_pkg::*;

  // Working widths. All intermediate values are exact; nothing wraps.
  localparam int CW  = COORD_BITS;
  localparam int IW  = INDEX_BITS;
  localparam int DW  = CW + 1;                         // coordinate differences
  localparam int SW  = 2 * CW + 4;                     // squared distances, alpha, beta
  localparam int GW  = max3(SW, EPS_BITS + 1, 0) + 1;  // distance minus epsilon
  localparam int XW  = SW + 1;                         // beta difference
  localparam int DDW = SW + GW + 1;                    // discriminants
  localparam int YW  = max3(DDW, 2 * XW, 0) + 2;       // y
  localparam int MW  = YW;                             // multiplier operand width
  localparam int PW  = 2 * MW;                         // y squared and 4 D_R D_U

  // The sequencer walks the products in dependency order. Each step issues one
  // multiplication to the shared unit and folds the product into its register.
  typedef enum logic [4:0] {
    ST_AXX, ST_AYY, ST_RXX, ST_RYY, ST_UXX, ST_UYY, ST_EXX, ST_EYY,
    ST_BRX, ST_BRY, ST_BUX, ST_BUY, ST_BRR, ST_GRA, ST_BUU, ST_GUA,
    ST_XX,  ST_YY,  ST_DD
  } step_t;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_t;

  // Configuration registers.
  logic signed [CW-1:0]       sx_r, sy_r, ex_r, ey_r;
  logic [EPS_BITS-1:0]        eps_r;
  logic [IW-1:0]              sidx_r;

  // Restriction state.
  logic signed [CW-1:0]       rx_r, ry_r;
  logic [IW-1:0]              ridx_r;
  logic                       dead_r;

  // Current point and control.
  logic signed [CW-1:0]       ux_r, uy_r;
  logic [IW-1:0]              uidx_r;
  logic                       skip_r;
  state_t                     state_r;
  step_t                      step_r;

  // Intermediate results.
  logic signed [SW-1:0]       alpha_r, rd_r, ud_r, ue_r, br_r, bu_r;
  logic signed [DDW-1:0]      dr_r, du_r;
  logic signed [YW-1:0]       y_r;
  logic signed [PW-1:0]       y2_r, dp_r;

  // Output register.
  logic                       out_valid_r;
  outcome_t                   out_outcome_r;
  logic [IW-1:0]              out_idx_r;

  // Multiplier connections.
  logic                       mul_start;
  logic signed [MW-1:0]       mul_a, mul_b;
  logic                       mul_done;
  logic signed [2*MW-1:0]     mul_p;

  // Combinational operands.
  logic signed [DW-1:0]       dax, day, drx, dry, dux, duy, dex, dey;
  logic signed [GW-1:0]       eps_g, gr, gu;
  logic signed [XW-1:0]       xd, bu_lo;

  // Decision terms.
  logic                       reach, x_ge, x_le, du_le, du_ge, y_le, y_ge, cy_le, cy_ge;
  outcome_t                   decided, res;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r   <= '0;
      sy_r   <= '0;
      ex_r   <= '0;
      ey_r   <= '0;
      eps_r  <= '0;
      sidx_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEG_START_X: sx_r   <= cfg_wdata[CW-1:0];
        REG_SEG_START_Y: sy_r   <= cfg_wdata[CW-1:0];
        REG_SEG_END_X:   ex_r   <= cfg_wdata[CW-1:0];
        REG_SEG_END_Y:   ey_r   <= cfg_wdata[CW-1:0];
        REG_EPSILON_SQ:  eps_r  <= cfg_wdata[EPS_BITS-1:0];
        REG_START_INDEX: sidx_r <= cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  // Differences against the segment. beta is formed as the negated sum of
  // products of (E - S) with (P - S), so the same differences serve both.
  assign dax = DW'(ex_r) - DW'(sx_r);
  assign day = DW'(ey_r) - DW'(sy_r);
  assign drx = DW'(rx_r) - DW'(sx_r);
  assign dry = DW'(ry_r) - DW'(sy_r);
  assign dux = DW'(ux_r) - DW'(sx_r);
  assign duy = DW'(uy_r) - DW'(sy_r);
  assign dex = DW'(ux_r) - DW'(ex_r);
  assign dey = DW'(uy_r) - DW'(ey_r);

  assign eps_g = {{(GW - EPS_BITS){1'b0}}, eps_r};
  assign gr    = GW'(rd_r) - eps_g;
  assign gu    = GW'(ud_r) - eps_g;
  assign xd    = XW'(br_r) - XW'(bu_r);
  assign bu_lo = XW'(bu_r) + XW'(alpha_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      ST_AXX: begin mul_a = MW'(dax);  mul_b = MW'(dax);     end
      ST_AYY: begin mul_a = MW'(day);  mul_b = MW'(day);     end
      ST_RXX: begin mul_a = MW'(drx);  mul_b = MW'(drx);     end
      ST_RYY: begin mul_a = MW'(dry);  mul_b = MW'(dry);     end
      ST_UXX: begin mul_a = MW'(dux);  mul_b = MW'(dux);     end
      ST_UYY: begin mul_a = MW'(duy);  mul_b = MW'(duy);     end
      ST_EXX: begin mul_a = MW'(dex);  mul_b = MW'(dex);     end
      ST_EYY: begin mul_a = MW'(dey);  mul_b = MW'(dey);     end
      ST_BRX: begin mul_a = MW'(dax);  mul_b = MW'(drx);     end
      ST_BRY: begin mul_a = MW'(day);  mul_b = MW'(dry);     end
      ST_BUX: begin mul_a = MW'(dax);  mul_b = MW'(dux);     end
      ST_BUY: begin mul_a = MW'(day);  mul_b = MW'(duy);     end
      ST_BRR: begin mul_a = MW'(br_r); mul_b = MW'(br_r);    end
      ST_GRA: begin mul_a = MW'(gr);   mul_b = MW'(alpha_r); end
      ST_BUU: begin mul_a = MW'(bu_r); mul_b = MW'(bu_r);    end
      ST_GUA: begin mul_a = MW'(gu);   mul_b = MW'(alpha_r); end
      ST_XX:  begin mul_a = MW'(xd);   mul_b = MW'(xd);      end
      ST_YY:  begin mul_a = y_r;       mul_b = y_r;          end
      ST_DD:  begin mul_a = MW'(dr_r); mul_b = MW'(du_r);    end
      default: ;
    endcase
  end

  assign mul_start = (state_r == S_ISSUE);

  fsr_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // The point reaches the segment if it is within epsilon of either end, or
  // its foot lies on the segment and its line distance is within epsilon.
  // The last test, |U-S|^2 alpha - beta_U^2 <= eps alpha, is exactly D_U >= 0.
  assign reach = (GW'(ud_r) <= eps_g) || (GW'(ue_r) <= eps_g) ||
                 ((bu_r <= 0) && (bu_lo >= 0) && (du_r >= 0));
  assign x_ge  = (xd >= 0);
  assign x_le  = (xd <= 0);
  assign du_le = (du_r <= dr_r);
  assign du_ge = (du_r >= dr_r);
  assign y_le  = (y_r <= 0);
  assign y_ge  = (y_r >= 0);
  assign cy_le = (y2_r <= dp_r);
  assign cy_ge = (y2_r >= dp_r);

  always_comb begin
    if (!reach) begin
      decided = OUT_DEAD;
    end else if ((x_ge && du_le) || (x_ge && du_ge && (y_le || cy_le)) ||
                 (x_le && du_le && y_ge && cy_ge)) begin
      decided = OUT_NEW;
    end else if (x_ge || y_ge || cy_le) begin
      decided = OUT_KEPT;
    end else begin
      decided = OUT_DEAD;
    end
  end

  assign res = skip_r ? OUT_DEAD : decided;

  // Sequencer, restriction state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_AXX;
      skip_r      <= 1'b0;
      rx_r        <= '0;
      ry_r        <= '0;
      ridx_r      <= '0;
      dead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The finishing state loads the output register itself.
      if (out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ux_r   <= in_point_x;
            uy_r   <= in_point_y;
            uidx_r <= in_point_index;
            step_r <= ST_AXX;
            // A restart takes effect before the point is tested.
            if (in_restart) begin
              rx_r   <= sx_r;
              ry_r   <= sy_r;
              ridx_r <= sidx_r;
              dead_r <= 1'b0;
            end
            skip_r  <= dead_r && !in_restart;
            state_r <= (dead_r && !in_restart) ? S_FIN : S_ISSUE;
          end
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            case (step_r)
              ST_AXX: alpha_r <= $signed(mul_p[SW-1:0]);
              ST_AYY: alpha_r <= alpha_r + $signed(mul_p[SW-1:0]);
              ST_RXX: rd_r    <= $signed(mul_p[SW-1:0]);
              ST_RYY: rd_r    <= rd_r + $signed(mul_p[SW-1:0]);
              ST_UXX: ud_r    <= $signed(mul_p[SW-1:0]);
              ST_UYY: ud_r    <= ud_r + $signed(mul_p[SW-1:0]);
              ST_EXX: ue_r    <= $signed(mul_p[SW-1:0]);
              ST_EYY: ue_r    <= ue_r + $signed(mul_p[SW-1:0]);
              ST_BRX: br_r    <= -$signed(mul_p[SW-1:0]);
              ST_BRY: br_r    <= br_r - $signed(mul_p[SW-1:0]);
              ST_BUX: bu_r    <= -$signed(mul_p[SW-1:0]);
              ST_BUY: bu_r    <= bu_r - $signed(mul_p[SW-1:0]);
              ST_BRR: dr_r    <= $signed(mul_p[DDW-1:0]);
              ST_GRA: dr_r    <= dr_r - $signed(mul_p[DDW-1:0]);
              ST_BUU: du_r    <= $signed(mul_p[DDW-1:0]);
              ST_GUA: du_r    <= du_r - $signed(mul_p[DDW-1:0]);
              ST_XX:  y_r     <= YW'(dr_r) + YW'(du_r) - $signed(mul_p[YW-1:0]);
              ST_YY:  y2_r    <= $signed(mul_p[PW-1:0]);
              ST_DD:  dp_r    <= $signed({mul_p[PW-3:0], 2'b00});
              default: ;
            endcase
            if (step_r == ST_DD) begin
              state_r <= S_FIN;
            end else begin
              step_r  <= step_t'(step_r + 1'b1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          // Hold the decision until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_outcome_r <= res;
            case (res)
              OUT_NEW: begin
                rx_r      <= ux_r;
                ry_r      <= uy_r;
                ridx_r    <= uidx_r;
                out_idx_r <= uidx_r;
              end
              OUT_KEPT: out_idx_r <= ridx_r;
              default: begin
                dead_r    <= 1'b1;
                out_idx_r <= '0;
              end
            endcase
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_outcome           = out_outcome_r;
  assign out_restriction_index = out_idx_r;

endmodule

`default_nettype wire
